/* rtl/core/psp_pkg.sv */
// Package for the progressive subdivision point order block.
// Holds sizes, the rectangle type, the control state encoding and the dimension clamp.
// No dependencies.
package psp_pkg;

  localparam int MAX_DIM     = 256;
  localparam int LEVEL_DEPTH = 65536;

  localparam int CFG_W   = 9;                       // config register width
  localparam int COORD_W = $clog2(MAX_DIM + 1);     // coordinate incl. far edge
  localparam int POINT_W = 8;                       // emitted coordinate width
  localparam int ADDR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = ADDR_W + 1;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic  have;
    rect_t child;
  } split_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_SPLIT,
    ST_POST
  } state_t;

  function automatic coord_t clamp_dim(input logic [CFG_W-1:0] v);
    coord_t r;
    if (v == '0) begin
      r = COORD_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = COORD_W'(MAX_DIM);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/core/psp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/psp_split.sv */
// Child geometry for one rectangle and one child index.
// Depends on psp_pkg.
module psp_split (
  input  psp_pkg::rect_t  rect,
  input  logic [1:0]      child_idx,
  output psp_pkg::split_t split
);

  psp_pkg::coord_t           w;
  psp_pkg::coord_t           h;
  logic [psp_pkg::COORD_W:0] sum_x;
  logic [psp_pkg::COORD_W:0] sum_y;
  psp_pkg::coord_t           mx;
  psp_pkg::coord_t           my;
  logic                      cx;
  logic                      cy;
  logic                      wide;
  logic                      tall;

  always_comb begin
    w = (rect.bx >= rect.ax) ? rect.bx - rect.ax : '0;
    h = (rect.by >= rect.ay) ? rect.by - rect.ay : '0;
    sum_x = {1'b0, rect.ax} + {1'b0, rect.bx};
    sum_y = {1'b0, rect.ay} + {1'b0, rect.by};
    mx = sum_x[psp_pkg::COORD_W:1];
    my = sum_y[psp_pkg::COORD_W:1];
    wide = (w >= psp_pkg::COORD_W'(2));
    tall = (h >= psp_pkg::COORD_W'(2));

    cx = 1'b0;
    cy = 1'b0;
    split.have = 1'b1;
    if (wide && tall) begin
      cx = child_idx[0];
      cy = child_idx[1];
    end else if (wide && !child_idx[1]) begin
      cx = child_idx[0];
    end else if (tall && !child_idx[1]) begin
      cy = child_idx[0];
    end else begin
      split.have = 1'b0;
    end

    split.child.ax = cx ? mx : rect.ax;
    split.child.bx = cx ? rect.bx : mx;
    split.child.ay = cy ? my : rect.ay;
    split.child.by = cy ? rect.by : my;
  end

endmodule

/* rtl/core/progressive_subdivision_point_order_top.sv */
// Top level of the progressive subdivision point order generator.
// Depends on psp_pkg, psp_ram and psp_split.
//
// Usage:
//   Input channel (in_valid/in_ready, field restart): each transaction asks for
//   one point. restart=1 starts over at the origin; restart=0 asks for the next
//   point. The first request after reset always yields the origin.
//   Output channel (out_valid/out_ready): one result transaction per request,
//   carrying point_x, point_y, last (final point) and exhausted (no point left;
//   coordinates and last are then zero).
//   Config port: cfg_write with cfg_index 0 = image_width, 1 = image_height,
//   both clamped to 1..256; they take effect at the next origin.
// Walk:
//   One request is worked on at a time. The block keeps one point of lookahead,
//   so each request runs the subdivision walk up to the next emitted corner.
//   A walk examines one child per step in the split state; a rectangle from
//   the level store is read through a read-issue state and a wait state for the
//   registered RAM data, and a level change is made in the read state. Taking
//   the request and posting the result are states of their own. A run of 1x1
//   rectangles at the finest level stretches one point, since each skipped
//   rectangle is still read and all its children are examined.
//   The exhausted answer skips the walk and goes straight to posting.
// Reset: synchronous, active high. Registers return to 256x256, the generator
//   returns to "origin pending". The stores need no clearing pass.
// Stall: the result sits in the output register; a new request is accepted
//   meanwhile, and its walk runs, but it waits to post until the old result
//   has been taken.
module progressive_subdivision_point_order_top (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [psp_pkg::CFG_W-1:0]   cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psp_pkg::POINT_W-1:0] point_x,
  output logic [psp_pkg::POINT_W-1:0] point_y,
  output logic                        last,
  output logic                        exhausted
);

  // configuration registers
  logic [psp_pkg::CFG_W-1:0] image_width;
  logic [psp_pkg::CFG_W-1:0] image_height;

  // walk control
  psp_pkg::state_t           state;
  psp_pkg::state_t           state_next;
  logic                      origin_pending;
  logic                      cur_bank;      // bank holding the current level
  logic                      root_level;    // current level is the whole image
  logic [psp_pkg::CNT_W-1:0] read_pos;
  logic [psp_pkg::CNT_W-1:0] cur_count;
  logic [psp_pkg::CNT_W-1:0] next_count;
  logic [1:0]                child_idx;
  logic                      split_seen;
  logic                      rect_valid;    // rect_q holds the rectangle at read_pos
  psp_pkg::rect_t            rect_q;
  psp_pkg::coord_t           root_w;
  psp_pkg::coord_t           root_h;

  // lookahead point and pending result
  logic                      ahead_valid;
  psp_pkg::coord_t           ahead_x;
  psp_pkg::coord_t           ahead_y;
  psp_pkg::coord_t           pend_x;
  psp_pkg::coord_t           pend_y;
  logic                      pend_exh;

  // datapath
  psp_pkg::split_t           split;
  psp_pkg::rect_t            root_rect;
  logic                      in_acc;
  logic                      start_req;
  logic                      lvl_more;
  logic                      emit;
  logic                      wr_en;
  logic                      out_load;
  logic [psp_pkg::ADDR_W-1:0] raddr;
  logic [psp_pkg::ADDR_W-1:0] waddr;
  logic [psp_pkg::RECT_W-1:0] rdata0;
  logic [psp_pkg::RECT_W-1:0] rdata1;
  logic [psp_pkg::RECT_W-1:0] rdata;

  assign in_acc    = in_valid && in_ready;
  assign start_req = restart || origin_pending;
  assign lvl_more  = (read_pos < cur_count);
  assign emit      = split.have && (child_idx != 2'd0);
  assign rdata     = cur_bank ? rdata1 : rdata0;

  always_comb begin
    root_rect.ax = '0;
    root_rect.ay = '0;
    root_rect.bx = root_w;
    root_rect.by = root_h;
  end

  psp_split u_split (
    .rect      (rect_q),
    .child_idx (child_idx),
    .split     (split)
  );

  // Two level stores used ping-pong: read current bank, write the other.
  // Reads and writes never target the same bank inside a level, and a bank
  // swap is made in the read state, after its last write.
  psp_ram #(.WIDTH(psp_pkg::RECT_W), .DEPTH(psp_pkg::LEVEL_DEPTH)) u_store0 (
    .clk   (clk),
    .we    (wr_en && cur_bank),
    .waddr (waddr),
    .wdata (split.child),
    .raddr (raddr),
    .rdata (rdata0)
  );

  psp_ram #(.WIDTH(psp_pkg::RECT_W), .DEPTH(psp_pkg::LEVEL_DEPTH)) u_store1 (
    .clk   (clk),
    .we    (wr_en && !cur_bank),
    .waddr (waddr),
    .wdata (split.child),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      psp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (start_req || ahead_valid) ? psp_pkg::ST_READ : psp_pkg::ST_POST;
        end
      end
      psp_pkg::ST_READ: begin
        if (lvl_more) begin
          state_next = (rect_valid || root_level) ? psp_pkg::ST_SPLIT : psp_pkg::ST_WAIT;
        end else if (!split_seen) begin
          state_next = psp_pkg::ST_POST;
        end
      end
      psp_pkg::ST_WAIT: begin
        state_next = psp_pkg::ST_SPLIT;
      end
      psp_pkg::ST_SPLIT: begin
        if (emit) begin
          state_next = psp_pkg::ST_POST;
        end else if (child_idx == 2'd0) begin
          state_next = psp_pkg::ST_READ;
        end
      end
      psp_pkg::ST_POST: begin
        if (!out_valid || out_ready) begin
          state_next = psp_pkg::ST_IDLE;
        end
      end
      default: state_next = psp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = (state == psp_pkg::ST_IDLE);
    raddr    = read_pos[psp_pkg::ADDR_W-1:0];
    waddr    = next_count[psp_pkg::ADDR_W-1:0];
    wr_en    = (state == psp_pkg::ST_SPLIT) && split.have &&
               (next_count < psp_pkg::CNT_W'(psp_pkg::LEVEL_DEPTH));
    out_load = (state == psp_pkg::ST_POST) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= psp_pkg::CFG_W'(psp_pkg::MAX_DIM);
      image_height <= psp_pkg::CFG_W'(psp_pkg::MAX_DIM);
    end else if (cfg_write) begin
      unique case (cfg_index)
        psp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        psp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_pending <= 1'b1;
      ahead_valid    <= 1'b0;
      cur_bank       <= 1'b0;
      root_level     <= 1'b1;
      read_pos       <= '0;
      cur_count      <= psp_pkg::CNT_W'(1);
      next_count     <= '0;
      child_idx      <= 2'd3;
      split_seen     <= 1'b0;
      rect_valid     <= 1'b0;
    end else begin
      unique case (state)
        psp_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (start_req) begin
              origin_pending <= 1'b0;
              ahead_valid    <= 1'b0;
              root_level     <= 1'b1;
              read_pos       <= '0;
              cur_count      <= psp_pkg::CNT_W'(1);
              next_count     <= '0;
              child_idx      <= 2'd3;
              split_seen     <= 1'b0;
              rect_valid     <= 1'b0;
            end else if (ahead_valid) begin
              ahead_valid <= 1'b0;
            end
          end
        end
        psp_pkg::ST_READ: begin
          if (lvl_more) begin
            if (!rect_valid && root_level) begin
              rect_valid <= 1'b1;
            end
          end else if (split_seen) begin
            // level change: the filled bank becomes the current level
            cur_bank   <= !cur_bank;
            root_level <= 1'b0;
            cur_count  <= next_count;
            next_count <= '0;
            read_pos   <= '0;
            child_idx  <= 2'd3;
            split_seen <= 1'b0;
          end
        end
        psp_pkg::ST_WAIT: begin
          rect_valid <= 1'b1;
        end
        psp_pkg::ST_SPLIT: begin
          if (child_idx == 2'd0) begin
            read_pos   <= read_pos + psp_pkg::CNT_W'(1);
            child_idx  <= 2'd3;
            rect_valid <= 1'b0;
          end else begin
            child_idx <= child_idx - 2'd1;
          end
          if (split.have) begin
            split_seen <= 1'b1;
          end
          if (wr_en) begin
            next_count <= next_count + psp_pkg::CNT_W'(1);
          end
          if (emit) begin
            ahead_valid <= 1'b1;
          end
        end
        psp_pkg::ST_POST: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == psp_pkg::ST_IDLE && in_acc) begin
      if (start_req) begin
        root_w   <= psp_pkg::clamp_dim(image_width);
        root_h   <= psp_pkg::clamp_dim(image_height);
        pend_x   <= '0;
        pend_y   <= '0;
        pend_exh <= 1'b0;
      end else if (ahead_valid) begin
        pend_x   <= ahead_x;
        pend_y   <= ahead_y;
        pend_exh <= 1'b0;
      end else begin
        pend_exh <= 1'b1;
      end
    end
    if (state == psp_pkg::ST_READ && lvl_more && !rect_valid && root_level) begin
      rect_q <= root_rect;
    end
    if (state == psp_pkg::ST_WAIT) begin
      rect_q <= psp_pkg::rect_t'(rdata);
    end
    if (state == psp_pkg::ST_SPLIT && emit) begin
      ahead_x <= split.child.ax;
      ahead_y <= split.child.ay;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_x   <= pend_exh ? '0 : pend_x[psp_pkg::POINT_W-1:0];
      point_y   <= pend_exh ? '0 : pend_y[psp_pkg::POINT_W-1:0];
      last      <= pend_exh ? 1'b0 : !ahead_valid;
      exhausted <= pend_exh;
    end
  end

endmodule

/* rtl/core/psp_checker.sv */
// Port-level checks for the progressive subdivision point order block,
// bound to the top level. Depends on psp_pkg.
module psp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        restart,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [psp_pkg::POINT_W-1:0] point_x,
  input logic [psp_pkg::POINT_W-1:0] point_y,
  input logic                        last,
  input logic                        exhausted
);

  // reset leaves the block ready with no result pending
  a_reset_state: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // one request in flight: acceptance drops ready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while walk busy");

  // exhausted result carries zero coordinates and no last flag
  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> point_x == '0 && point_y == '0 && !last)
    else $error("exhausted result not cleared");

  // a waiting request keeps valid and its restart flag
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(restart))
    else $error("request changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y) &&
    $stable(last) && $stable(exhausted))
    else $error("result changed under stall");

endmodule

bind progressive_subdivision_point_order_top psp_checker u_psp_checker (.*);
